/* hw/rtl/pwi_pkg.sv */
// ----------------------------------------------------------------------------
// pwi_pkg
// Shared types and fixed widths for the polyline waypoint interpolator.
// ----------------------------------------------------------------------------
package pwi_pkg;

	localparam int COORD_W = 16;                 // signed Q7.8 coordinate
	localparam int PATH_W  = 3;
	localparam int RES_W   = 16;                 // unsigned Q8.8 spacing
	localparam int MAG_W   = 16;                 // |dx|, |dy| never exceed 65535
	localparam int DIST_W  = 34;                 // dx^2 + dy^2
	localparam int ROOT_W  = 17;                 // isqrt of DIST_W bits
	localparam int ALU_W   = 20;                 // shared subtractor width
	localparam int CNT_W   = 5;                  // iteration counter

	localparam int SQRT_STEPS = DIST_W / 2;      // one root bit per step
	localparam int NDIV_STEPS = ROOT_W;          // root / resolution
	localparam int MDIV_STEPS = MAG_W;           // magnitude / step count

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic        [PATH_W-1:0]  path_t;
	typedef logic        [RES_W-1:0]   res_t;
	typedef logic        [MAG_W-1:0]   mag_t;

endpackage

/* hw/rtl/polyline_waypoint_interpolator_unit.sv */
// A path-start corner is absorbed with no point. A zero-length segment goes from idle to
// the emit state and then the output register; a normal segment passes the x and y squaring
// states, the square root, the n divide, the x and y divides and emit, and zero resolution
// skips the root and the n divide. No new corner is taken until a segment's last point is
// emitted, as the single shared subtractor serves every step; an output stall holds emit.
// Reset: resolution returns to 64 (0.25), previous corner cleared to the origin, no path.
// ----------------------------------------------------------------------------
// polyline_waypoint_interpolator_unit
// Fills in evenly spaced points between consecutive polyline corners. A small
// sequencer drives one compare/subtract unit through an integer square root
// and restoring divisions, then steps both axes with a remainder accumulator.
// ----------------------------------------------------------------------------
module polyline_waypoint_interpolator_unit #(
	parameter int MAX_STEPS = 63
) (
	input  logic            clk,
	input  logic            arst_n,
	// configuration
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  pwi_pkg::res_t   cfg_data,
	// corner input
	input  logic            in_valid,
	output logic            in_ready,
	input  pwi_pkg::coord_t point_x,
	input  pwi_pkg::coord_t point_y,
	input  pwi_pkg::path_t  path_id,
	input  logic            path_start,
	// point output
	output logic            out_valid,
	input  logic            out_ready,
	output pwi_pkg::coord_t out_x,
	output pwi_pkg::coord_t out_y,
	output pwi_pkg::path_t  out_path,
	output logic            segment_end,
	output logic            clamped
);
	import pwi_pkg::*;

	localparam int NW = $clog2(MAX_STEPS + 1);   // step count / index width
	localparam int RW = NW + 2;                  // DDA remainder, below 4n

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQX  = 4'd1;
	localparam logic [3:0] ST_SQY  = 4'd2;
	localparam logic [3:0] ST_SQRT = 4'd3;
	localparam logic [3:0] ST_NDIV = 4'd4;
	localparam logic [3:0] ST_XDIV = 4'd5;
	localparam logic [3:0] ST_YDIV = 4'd6;
	localparam logic [3:0] ST_EMIT = 4'd7;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  iter_q;
	res_t              resolution_q;
	coord_t            prev_x_q, prev_y_q;
	logic              have_prev_q;
	coord_t            seg_x_q, seg_y_q;
	path_t             path_q;
	mag_t              magx_q, magy_q;
	logic              negx_q, negy_q;
	logic [DIST_W-1:0] dvd_q;
	logic [ALU_W-1:0]  rem_q;
	logic [ROOT_W-1:0] quo_q;
	logic              exact_q;
	logic [NW-1:0]     n_q, j_q;
	logic              clamp_q;
	mag_t              ax_q, ay_q, accx_q, accy_q;
	logic [NW-1:0]     bx_q, by_q;
	logic [RW-1:0]     rmx_q, rmy_q;

	coord_t            out_x_q, out_y_q;
	path_t             out_path_q;
	logic              out_valid_q, seg_end_q, clamped_q;

	// shared compare/subtract unit
	logic [ALU_W-1:0]  alu_cand, alu_trial, alu_rem;
	logic [ALU_W:0]    alu_diff;
	logic              alu_ge;
	logic [ROOT_W-1:0] alu_quo;

	always_comb begin
		if (state_q == ST_SQRT) begin
			alu_cand  = {rem_q[ALU_W-3:0], dvd_q[DIST_W-1 -: 2]};
			alu_trial = ALU_W'({quo_q, 2'b01});
		end else begin
			alu_cand  = {rem_q[ALU_W-2:0], dvd_q[DIST_W-1]};
			alu_trial = (state_q == ST_NDIV) ? ALU_W'(resolution_q) : ALU_W'(n_q);
		end
		alu_diff = {1'b0, alu_cand} - {1'b0, alu_trial};
		alu_ge   = !alu_diff[ALU_W];
		alu_rem  = alu_ge ? alu_diff[ALU_W-1:0] : alu_cand;
		alu_quo  = {quo_q[ROOT_W-2:0], alu_ge};
	end

	// squaring, one axis per cycle
	mag_t               mul_op;
	logic [2*MAG_W-1:0] mul_p;
	assign mul_op = (state_q == ST_SQX) ? magx_q : magy_q;
	assign mul_p  = mul_op * mul_op;

	// accept-side differences
	logic signed [COORD_W:0] dx, dy;
	assign dx = {point_x[COORD_W-1], point_x} - {prev_x_q[COORD_W-1], prev_x_q};
	assign dy = {point_y[COORD_W-1], point_y} - {prev_y_q[COORD_W-1], prev_y_q};

	logic [COORD_W:0] absx, absy;
	assign absx = dx[COORD_W] ? -dx : dx;
	assign absy = dy[COORD_W] ? -dy : dy;

	// step count from root / resolution: ceil when exact square, else floor + 1
	logic [ROOT_W:0] ncalc;
	assign ncalc = exact_q ? ({1'b0, alu_quo} + (ROOT_W+1)'(alu_rem != '0))
	                       : ({1'b0, alu_quo} + (ROOT_W+1)'(1));

	// DDA step for both axes
	logic [RW-1:0] two_n, rmx_sum, rmy_sum;
	logic          cx, cy;
	assign two_n   = RW'({n_q, 1'b0});
	assign rmx_sum = rmx_q + RW'({bx_q, 1'b0});
	assign rmy_sum = rmy_q + RW'({by_q, 1'b0});
	assign cx      = rmx_sum >= two_n;
	assign cy      = rmy_sum >= two_n;

	logic out_free;
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			iter_q       <= '0;
			resolution_q <= RES_W'(64);
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			have_prev_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				resolution_q <= cfg_data;
			// while emitting, the emit arm reloads the output register itself
			if (out_valid_q && out_ready && state_q != ST_EMIT)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						prev_x_q    <= point_x;
						prev_y_q    <= point_y;
						have_prev_q <= 1'b1;
						seg_x_q     <= prev_x_q;
						seg_y_q     <= prev_y_q;
						path_q      <= path_id;
						magx_q      <= absx[MAG_W-1:0];
						magy_q      <= absy[MAG_W-1:0];
						negx_q      <= dx[COORD_W];
						negy_q      <= dy[COORD_W];
						if (!path_start && have_prev_q) begin
							if (dx == '0 && dy == '0) begin
								// zero-length: emit the start point once
								n_q     <= '0;
								j_q     <= '0;
								clamp_q <= 1'b0;
								accx_q  <= '0;
								accy_q  <= '0;
								ax_q    <= '0;
								ay_q    <= '0;
								bx_q    <= '0;
								by_q    <= '0;
								rmx_q   <= '0;
								rmy_q   <= '0;
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_SQX;
							end
						end
					end
				end
				ST_SQX: begin
					dvd_q   <= DIST_W'(mul_p);
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					rem_q <= '0;
					quo_q <= '0;
					if (resolution_q == '0) begin
						n_q     <= NW'(MAX_STEPS);
						clamp_q <= 1'b1;
						dvd_q   <= {magx_q, (DIST_W-MAG_W)'(0)};
						iter_q  <= CNT_W'(MDIV_STEPS - 1);
						state_q <= ST_XDIV;
					end else begin
						dvd_q   <= dvd_q + DIST_W'(mul_p);
						iter_q  <= CNT_W'(SQRT_STEPS - 1);
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					dvd_q  <= dvd_q << 2;
					rem_q  <= alu_rem;
					quo_q  <= alu_quo;
					iter_q <= iter_q - 1'b1;
					if (iter_q == '0) begin
						exact_q <= (alu_rem == '0);
						dvd_q   <= {alu_quo, (DIST_W-ROOT_W)'(0)};
						rem_q   <= '0;
						quo_q   <= '0;
						iter_q  <= CNT_W'(NDIV_STEPS - 1);
						state_q <= ST_NDIV;
					end
				end
				ST_NDIV: begin
					dvd_q  <= dvd_q << 1;
					rem_q  <= alu_rem;
					quo_q  <= alu_quo;
					iter_q <= iter_q - 1'b1;
					if (iter_q == '0) begin
						if (ncalc > (ROOT_W+1)'(MAX_STEPS)) begin
							n_q     <= NW'(MAX_STEPS);
							clamp_q <= 1'b1;
						end else begin
							n_q     <= ncalc[NW-1:0];
							clamp_q <= 1'b0;
						end
						dvd_q   <= {magx_q, (DIST_W-MAG_W)'(0)};
						rem_q   <= '0;
						quo_q   <= '0;
						iter_q  <= CNT_W'(MDIV_STEPS - 1);
						state_q <= ST_XDIV;
					end
				end
				ST_XDIV: begin
					dvd_q  <= dvd_q << 1;
					rem_q  <= alu_rem;
					quo_q  <= alu_quo;
					iter_q <= iter_q - 1'b1;
					if (iter_q == '0) begin
						ax_q    <= alu_quo[MAG_W-1:0];
						bx_q    <= alu_rem[NW-1:0];
						dvd_q   <= {magy_q, (DIST_W-MAG_W)'(0)};
						rem_q   <= '0;
						quo_q   <= '0;
						iter_q  <= CNT_W'(MDIV_STEPS - 1);
						state_q <= ST_YDIV;
					end
				end
				ST_YDIV: begin
					dvd_q  <= dvd_q << 1;
					rem_q  <= alu_rem;
					quo_q  <= alu_quo;
					iter_q <= iter_q - 1'b1;
					if (iter_q == '0) begin
						ay_q    <= alu_quo[MAG_W-1:0];
						by_q    <= alu_rem[NW-1:0];
						// numerator starts at n, so the first quotient is 0
						accx_q  <= '0;
						accy_q  <= '0;
						rmx_q   <= RW'(n_q);
						rmy_q   <= RW'(n_q);
						j_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_x_q     <= negx_q ? seg_x_q - coord_t'(accx_q)
						                      : seg_x_q + coord_t'(accx_q);
						out_y_q     <= negy_q ? seg_y_q - coord_t'(accy_q)
						                      : seg_y_q + coord_t'(accy_q);
						out_path_q  <= path_q;
						seg_end_q   <= (j_q == n_q);
						clamped_q   <= clamp_q;
						accx_q      <= accx_q + ax_q + MAG_W'(cx);
						accy_q      <= accy_q + ay_q + MAG_W'(cy);
						rmx_q       <= cx ? rmx_sum - two_n : rmx_sum;
						rmy_q       <= cy ? rmy_sum - two_n : rmy_sum;
						j_q         <= j_q + 1'b1;
						if (j_q == n_q)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_path    = out_path_q;
	assign segment_end = seg_end_q;
	assign clamped     = clamped_q;

	// a new beat only ever comes from the emit sequencer
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> $past(state_q) == ST_EMIT)
		else $error("output beat raised outside emit");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> j_q <= n_q)
		else $error("point index ran past step count");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && n_q != '0) |-> (rmx_q < two_n && rmy_q < two_n))
		else $error("DDA remainder out of range");

	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (accx_q <= magx_q && accy_q <= magy_q))
		else $error("offset passed segment end");

	a_clamp_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && clamp_q) |-> n_q == NW'(MAX_STEPS))
		else $error("clamped segment without full step count");

endmodule

/* test/pwi_point_checker.sv */
// ----------------------------------------------------------------------------
// pwi_point_checker
// Watches the configuration, corner and point channels of the waypoint
// interpolator, predicts every emitted point from the corners it sees, and
// compares each point beat against the oldest prediction.
// ----------------------------------------------------------------------------
module pwi_point_checker #(
	parameter int MAX_STEPS = 63
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  pwi_pkg::res_t   cfg_data,
	input  logic            in_valid,
	input  logic            in_ready,
	input  pwi_pkg::coord_t point_x,
	input  pwi_pkg::coord_t point_y,
	input  pwi_pkg::path_t  path_id,
	input  logic            path_start,
	input  logic            out_valid,
	input  logic            out_ready,
	input  pwi_pkg::coord_t out_x,
	input  pwi_pkg::coord_t out_y,
	input  pwi_pkg::path_t  out_path,
	input  logic            segment_end,
	input  logic            clamped,
	output int              mismatch_count,
	output int              points_waiting,
	output int              points_checked,
	output int              clamped_points
);
	import pwi_pkg::*;

	localparam res_t RES_AT_RESET = 16'd64;

	typedef struct packed {
		coord_t x;
		coord_t y;
		path_t  path;
		logic   seg_end;
		logic   clip;
	} waypoint_t;

	waypoint_t expected_points[$];
	res_t      spacing;
	coord_t    last_x;
	coord_t    last_y;
	logic      have_corner;
	int        errors;
	int        checked;
	int        flagged;

	// largest r with r*r <= v; dx^2 + dy^2 stays below 2^34
	function automatic longint int_sqrt(input longint v);
		longint lo;
		longint hi;
		longint mid;
		lo = 0;
		hi = 131072;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	// j * d / n rounded to nearest, halves away from zero
	function automatic int step_offset(input int d, input int j, input int n);
		longint mag;
		longint q;
		mag = (d < 0) ? -longint'(d) : longint'(d);
		q = (2 * mag * j + n) / (2 * longint'(n));
		return (d < 0) ? -int'(q) : int'(q);
	endfunction

	task queue_point(input waypoint_t p);
		expected_points.insert(expected_points.size(), p);
	endtask

	task add_corner(input coord_t ex, input coord_t ey, input path_t pid, input logic start);
		int        sx;
		int        sy;
		int        dx;
		int        dy;
		int        n;
		longint    dist2;
		longint    root;
		longint    steps;
		logic      clip;
		waypoint_t p;
		sx = last_x;
		sy = last_y;
		last_x = ex;
		last_y = ey;
		if (start || !have_corner) begin
			have_corner = 1'b1;
			return;
		end
		dx = int'(ex) - sx;
		dy = int'(ey) - sy;
		dist2 = longint'(dx) * dx + longint'(dy) * dy;
		if (dist2 == 0) begin
			p = '{x: coord_t'(sx), y: coord_t'(sy), path: pid, seg_end: 1'b1, clip: 1'b0};
			queue_point(p);
			return;
		end
		if (spacing == 0) begin
			steps = MAX_STEPS + 1;
		end else begin
			root = int_sqrt(dist2);
			if (root * root == dist2) steps = (root + spacing - 1) / spacing;
			else steps = root / spacing + 1;
		end
		clip = (steps > MAX_STEPS);
		n = clip ? MAX_STEPS : int'(steps);
		for (int j = 0; j <= n; j++) begin
			p.x = coord_t'(sx + step_offset(dx, j, n));
			p.y = coord_t'(sy + step_offset(dy, j, n));
			p.path = pid;
			p.seg_end = (j == n);
			p.clip = clip;
			queue_point(p);
		end
	endtask

	task report_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		waypoint_t want;
		if (!arst_n) begin
			expected_points.delete();
			spacing = RES_AT_RESET;
			last_x = '0;
			last_y = '0;
			have_corner = 1'b0;
			errors = 0;
			checked = 0;
			flagged = 0;
			mismatch_count <= 0;
			points_waiting <= 0;
			points_checked <= 0;
			clamped_points <= 0;
		end else begin
			if (cfg_valid && cfg_ready) spacing = cfg_data;
			if (in_valid && in_ready) add_corner(point_x, point_y, path_id, path_start);
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected point (%0d, %0d) path %0d", $time,
						out_x, out_y, out_path);
					errors++;
				end else begin
					want = expected_points.pop_front();
					report_field("out_x", want.x, out_x);
					report_field("out_y", want.y, out_y);
					report_field("out_path", want.path, out_path);
					report_field("segment_end", want.seg_end, segment_end);
					report_field("clamped", want.clip, clamped);
					checked++;
					if (want.clip) flagged++;
				end
			end
			mismatch_count <= errors;
			points_waiting <= expected_points.size();
			points_checked <= checked;
			clamped_points <= flagged;
		end
	end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives corners and resolution writes into the waypoint interpolator with
// bursty input and a stalling point sink; the checker beside the block
// predicts and compares every point, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import pwi_pkg::*;

	localparam int MAX_STEPS  = 63;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE     = 100;
	localparam int LONG_HOLD  = 500;
	localparam int PHASE_LEN  = 78;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_ONE_IN_FOUR, READY_MOSTLY} sink_mode_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	res_t   cfg_data = '0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	coord_t point_x = '0;
	coord_t point_y = '0;
	path_t  path_id = '0;
	logic   path_start = 1'b0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	coord_t out_x;
	coord_t out_y;
	path_t  out_path;
	logic   segment_end;
	logic   clamped;

	int mismatch_count;
	int points_waiting;
	int points_checked;
	int clamped_points;

	int   burst_left = 0;
	int   corners_sent = 0;
	int   res_writes = 0;
	int   cur_x = 0;
	int   cur_y = 0;
	int   cur_id = 0;
	int   path_left = 0;
	logic hold_toggle = 1'b0;

	polyline_waypoint_interpolator_unit #(.MAX_STEPS(MAX_STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .path_id(path_id), .path_start(path_start),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_path(out_path),
		.segment_end(segment_end), .clamped(clamped)
	);

	pwi_point_checker #(.MAX_STEPS(MAX_STEPS)) u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .path_id(path_id), .path_start(path_start),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_path(out_path),
		.segment_end(segment_end), .clamped(clamped),
		.mismatch_count(mismatch_count), .points_waiting(points_waiting),
		.points_checked(points_checked), .clamped_points(clamped_points)
	);

	always #2 clk = ~clk;

	// point sink: random stall modes, plus a long hold-off on each toggle request
	logic       hold_seen = 1'b0;
	int         hold_left = 0;
	int         mode_left = 0;
	int         sink_cycle = 0;
	sink_mode_t sink_mode = READY_ALWAYS;

	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			sink_cycle++;
			case (sink_mode)
				READY_ALWAYS:      out_ready <= 1'b1;
				READY_COIN:        out_ready <= ($urandom_range(0, 1) == 1);
				READY_ONE_IN_FOUR: out_ready <= (sink_cycle % 4 == 0);
				default:           out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// watchdog: too long without any beat on any channel
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task send_corner(input int x, input int y, input int id, input logic start);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		point_x <= coord_t'(x);
		point_y <= coord_t'(y);
		path_id <= path_t'(id);
		path_start <= start;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		cur_x = x;
		cur_y = y;
		corners_sent++;
	endtask

	task wait_drained;
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (points_waiting != 0) @(posedge clk);
	endtask

	task set_resolution(input int value);
		wait_drained();
		// a path-start corner leaves no point behind to wait for
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= res_t'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		res_writes++;
	endtask

	function automatic int clip16(input int v);
		return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
	endfunction

	// mostly well-formed paths of nearby corners, with repeats and stray starts
	task send_random_corner;
		int   span;
		int   nx;
		int   ny;
		logic start;
		start = 1'b0;
		if (path_left == 0) begin
			path_left = $urandom_range(3, 15);
			cur_id = $urandom_range(0, 7);
			nx = int'($urandom_range(0, 65535)) - 32768;
			ny = int'($urandom_range(0, 65535)) - 32768;
			start = 1'b1;
		end else begin
			path_left--;
			case ($urandom_range(0, 9))
				0: begin
					nx = cur_x;
					ny = cur_y;
				end
				1: begin
					nx = int'($urandom_range(0, 65535)) - 32768;
					ny = int'($urandom_range(0, 65535)) - 32768;
					start = ($urandom_range(0, 1) == 1);
					cur_id = $urandom_range(0, 7);
				end
				default: begin
					case ($urandom_range(0, 3))
						0:       span = 8;
						1:       span = 256;
						2:       span = 4096;
						default: span = 32768;
					endcase
					nx = clip16(cur_x + int'($urandom_range(0, 2 * span)) - span);
					ny = clip16(cur_y + int'($urandom_range(0, 2 * span)) - span);
					start = ($urandom_range(0, 19) == 0);
				end
			endcase
		end
		send_corner(nx, ny, cur_id, start);
	endtask

	initial begin
		int phase_res[5];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset spacing of 0.25
		send_corner(256, 512, 1, 1'b0);           // no previous corner yet
		send_corner(512, 512, 2, 1'b0);
		send_corner(512, 512, 3, 1'b0);           // zero length
		send_corner(-32768, -32768, 7, 1'b1);
		send_corner(32767, 32767, 0, 1'b0);       // full diagonal, clamped
		send_corner(-32768, 32767, 5, 1'b0);
		send_corner(-32768, 32767, 4, 1'b0);
		send_corner(0, 0, 6, 1'b1);
		send_corner(3, -5, 6, 1'b0);
		send_corner(-3, 5, 1, 1'b0);

		set_resolution(0);                        // zero spacing, step count clamped to MAX_STEPS
		send_corner(10, 10, 2, 1'b0);
		send_corner(10, 10, 2, 1'b0);

		set_resolution(2);                        // rounding of exact halves
		send_corner(0, 0, 3, 1'b1);
		send_corner(3, 0, 3, 1'b0);
		send_corner(0, 0, 3, 1'b0);
		send_corner(0, -3, 3, 1'b0);

		set_resolution(65535);
		send_corner(32767, -32768, 3, 1'b1);
		send_corner(-32768, 32767, 3, 1'b0);

		set_resolution(1);                        // step count at and just above the cap
		send_corner(0, 0, 2, 1'b1);
		send_corner(63, 0, 2, 1'b0);
		send_corner(63, 64, 2, 1'b0);

		phase_res[0] = 32;
		phase_res[1] = 1;
		phase_res[2] = 65535;
		phase_res[3] = 0;
		phase_res[4] = $urandom_range(2, 4096);
		for (int ph = 0; ph < 5; ph++) begin
			set_resolution(phase_res[ph]);
			path_left = 0;
			// fill the block while the sink is held off
			if (ph == 1) hold_toggle <= ~hold_toggle;
			for (int i = 0; i < PHASE_LEN; i++) send_random_corner();
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		$display("corners sent: %0d, resolution writes: %0d", corners_sent, res_writes);
		$display("points checked: %0d, clamped: %0d", points_checked, clamped_points);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
